### rtl/mrbt_pkg.sv
`default_nettype none
package mrbt_pkg;
  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_GCD_INIT,
    S_GCD_STEP,
    S_GCD_EVAL,
    S_SPLIT,
    S_RED,
    S_POW_BIT,
    S_MUL,
    S_POW_NEXT,
    S_SQ_EVAL,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MD_POW_R,
    MD_POW_X,
    MD_SQ
  } mul_dst_t;
endpackage
`default_nettype wire

### rtl/miller_rabin_single_base_test.sv
`default_nettype none
// Single-base strong probable-prime test on one WORD_BITS-bit candidate.
// Command channel: drive candidate and witness_base with start high; the
// transaction is taken at a rising edge where busy is low. busy stays high
// from the next cycle and falls in the cycle in which the verdict is shown.
// Result channel: probable_prime is valid for one cycle while done is high.
// The receiver cannot stall; the verdict is shown once and dropped.
// When the candidate is 2, below 2 or even, the verdict follows the check
// directly. Otherwise a gcd runs on a restoring remainder unit, one Euclid
// step at a time, and the base is then reduced modulo the candidate on the
// same unit. Then comes a powering loop of modular multiplications and the
// squaring checks, all on one shared shift-and-add unit.
// One transaction is processed at a time; the next can be taken in the cycle
// in which done is high.
// Reset (rst, synchronous) returns the sequencer to idle and clears done.
module miller_rabin_single_base_test
  import mrbt_pkg::*;
#(
  parameter int WORD_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] candidate,
  input  wire logic [63:0] witness_base,
  output logic             done,
  output logic             probable_prime
);
  localparam int CW = $clog2(WORD_BITS + 2);
  typedef logic [WORD_BITS-1:0] w_t;

  state_t state, state_next;
  w_t n, b, ga, gb, q, nm1, r, x, rem, quo_src, ma, mb, acc, tmp;
  logic [CW-1:0] cnt, p;
  logic [CW-1:0] j;
  mul_dst_t dst;
  logic verdict;

  // shared step helpers (modular add: one subtract, one compare, then add or subtract)
  function automatic w_t addmod(w_t a, w_t c, w_t m);
    w_t room;
    room = m - c;
    return (a >= room) ? (a - room) : (a + c);
  endfunction

  logic [WORD_BITS:0] rem_sh;
  w_t mul_step, mul_d;
  assign rem_sh = {rem, quo_src[WORD_BITS-1]};
  assign mul_d = addmod(acc, acc, n);
  assign mul_step = mb[WORD_BITS-1] ? addmod(mul_d, ma, n) : mul_d;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (start) state_next = S_CHECK;
      S_CHECK:    state_next = (n == w_t'(2) || n < w_t'(2) || !n[0]) ? S_DONE : S_GCD_INIT;
      S_GCD_INIT: state_next = S_GCD_STEP;
      S_GCD_STEP: state_next = (gb == '0) ? S_GCD_EVAL :
                               (cnt == CW'(WORD_BITS)) ? S_GCD_STEP : S_GCD_STEP;
      S_GCD_EVAL: state_next = (ga == w_t'(1)) ? S_SPLIT : (ga < n) ? S_DONE : S_GCD_INIT;
      S_SPLIT:    state_next = q[0] ? S_RED : S_SPLIT;
      S_RED:      state_next = (cnt == CW'(WORD_BITS)) ? S_POW_BIT : S_RED;
      S_POW_BIT:  state_next = (q == '0) ? S_SQ_EVAL : S_MUL;
      S_MUL:      state_next = (cnt == CW'(WORD_BITS)) ? S_POW_NEXT : S_MUL;
      S_POW_NEXT: state_next = (dst == MD_SQ) ? S_SQ_EVAL : S_MUL;
      S_SQ_EVAL:  state_next = S_DONE;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
    if (state == S_GCD_STEP && gb != '0) state_next = S_GCD_STEP;
    if (state == S_POW_NEXT && dst == MD_POW_R) state_next = S_MUL;
    if (state == S_POW_NEXT && dst == MD_POW_X) state_next = S_POW_BIT;
    if (state == S_SQ_EVAL && !(r == nm1 || (j == '0 && r == w_t'(1))) &&
        (j + 1'b1) < p) state_next = S_MUL;
  end

  always_comb begin
    busy = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_DONE);
    end
    probable_prime <= verdict;
    case (state)
      S_IDLE: if (start) begin
        n <= candidate[WORD_BITS-1:0];
        b <= (witness_base[WORD_BITS-1:0] < w_t'(2)) ? w_t'(2) : witness_base[WORD_BITS-1:0];
      end
      S_CHECK: verdict <= (n == w_t'(2));
      S_GCD_INIT: begin
        ga <= n; gb <= b; rem <= '0; quo_src <= n; cnt <= '0;
      end
      S_GCD_STEP: if (gb != '0) begin
        if (cnt == CW'(WORD_BITS)) begin
          ga <= gb; gb <= rem; rem <= '0; quo_src <= gb; cnt <= '0;
        end else begin
          rem <= (rem_sh >= {1'b0, gb}) ? w_t'(rem_sh - {1'b0, gb}) : rem_sh[WORD_BITS-1:0];
          quo_src <= quo_src << 1;
          cnt <= cnt + 1'b1;
        end
      end
      S_GCD_EVAL: begin
        verdict <= 1'b0;
        if (ga != w_t'(1)) b <= b + 1'b1;
        nm1 <= n - 1'b1; q <= n - 1'b1; p <= '0;
      end
      S_SPLIT: if (!q[0]) begin
        q <= q >> 1; p <= p + 1'b1;
      end else begin
        rem <= '0; quo_src <= b; cnt <= '0; gb <= n;
      end
      S_RED: begin
        if (cnt == CW'(WORD_BITS)) begin
          x <= rem; r <= w_t'(1); j <= '0;
        end else begin
          rem <= (rem_sh >= {1'b0, n}) ? w_t'(rem_sh - {1'b0, n}) : rem_sh[WORD_BITS-1:0];
          quo_src <= quo_src << 1;
          cnt <= cnt + 1'b1;
        end
      end
      S_POW_BIT: begin
        acc <= '0; cnt <= '0;
        if (q[0]) begin dst <= MD_POW_R; ma <= r; mb <= x; end
        else begin dst <= MD_POW_X; ma <= x; mb <= x; end
      end
      S_MUL: if (cnt == CW'(WORD_BITS)) begin
        tmp <= acc;
      end else begin
        acc <= mul_step; mb <= mb << 1; cnt <= cnt + 1'b1;
      end
      S_POW_NEXT: begin
        acc <= '0; cnt <= '0;
        case (dst)
          MD_POW_R: begin r <= tmp; dst <= MD_POW_X; ma <= x; mb <= x; end
          MD_POW_X: begin x <= tmp; q <= q >> 1; end
          MD_SQ:    begin r <= tmp; j <= j + 1'b1; end
          default:  ;
        endcase
      end
      S_SQ_EVAL: begin
        verdict <= (r == nm1) || (j == '0 && r == w_t'(1));
        dst <= MD_SQ; ma <= r; mb <= r; acc <= '0; cnt <= '0;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

### rtl/mrbt_checker.sv
`default_nettype none
module mrbt_assertions (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done longer than one cycle");
  a_take_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("transaction taken without busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  a_rst: assert property (@(posedge clk) rst |=> !done && !busy)
    else $error("reset not clean");
endmodule

bind miller_rabin_single_base_test mrbt_assertions u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done)
);
`default_nettype wire
